### hdl/assert_macros.svh
// Assertion macros for the checker file.
// ASSERT_CLKD checks a property on every rising clock edge outside reset.
// ASSERT_CLKD_RST checks a property on every rising clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLKD(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define ASSERT_CLKD_RST(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hdl/srit_pkg.sv
package srit_pkg;

  // Default coordinate width; the top level may override it.
  localparam int COORD_WIDTH_DEFAULT = 16;

  // Number of rectangle edges tested in rectangle mode.
  localparam int EDGE_COUNT = 4;

  // Request modes.
  localparam logic MODE_SEGMENT = 1'b0;
  localparam logic MODE_RECT    = 1'b1;

endpackage

### hdl/srit_if.sv
// Request channel: a mode and four points.
interface srit_in_if #(
  parameter int COORD_WIDTH = srit_pkg::COORD_WIDTH_DEFAULT
) ();
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [COORD_WIDTH-1:0] p_x;
  logic signed [COORD_WIDTH-1:0] p_y;
  logic signed [COORD_WIDTH-1:0] q_x;
  logic signed [COORD_WIDTH-1:0] q_y;
  logic signed [COORD_WIDTH-1:0] s_x;
  logic signed [COORD_WIDTH-1:0] s_y;
  logic signed [COORD_WIDTH-1:0] e_x;
  logic signed [COORD_WIDTH-1:0] e_y;

  modport source (
    output valid, mode, p_x, p_y, q_x, q_y, s_x, s_y, e_x, e_y,
    input  ready
  );
  modport sink (
    input  valid, mode, p_x, p_y, q_x, q_y, s_x, s_y, e_x, e_y,
    output ready
  );
endinterface

// Result channel: one hit flag per request.
interface srit_out_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

### hdl/segment_and_rect_intersection_test_top.sv
// Segment and rectangle intersection tester.
//
// The req channel carries one request per handshake: a mode bit and four
// points P, Q, S and E. In segment mode the block tests segment P-Q against
// segment S-E. In rectangle mode P and Q are opposite corners of an
// axis-aligned rectangle, and each of its four sides is tested against S-E.
// The res channel returns exactly one hit flag per request, in request order.
// A request is accepted at a rising edge with valid and ready both high.
//
// The request is captured in the input register, the cross products are
// formed and registered in the second stage, and the sign and range checks
// load the result register in the third stage. Throughput is one request
// per clock while res.ready is high; every stage is a plain register with
// no iteration, so the multipliers of the product stage set the clock period.
// Each stage holds its contents only while the stage after it is full and
// stalled, so a waiting result does not block new requests until all three
// stages are occupied.
//
// Reset (rst, synchronous, active high) empties all stages; payloads are
// not reset. All arithmetic is exact: products use 2*COORD_WIDTH+2 bits.
module segment_and_rect_intersection_test_top #(
  parameter int COORD_WIDTH = srit_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  srit_in_if.sink     req,
  srit_out_if.source  res
);

  localparam int DW = COORD_WIDTH + 1;       // width of a coordinate difference
  localparam int PW = 2 * COORD_WIDTH + 2;   // width of a product of differences
  localparam int SW = 2 * COORD_WIDTH + 3;   // width of a sum of two products
  localparam int NE = srit_pkg::EDGE_COUNT;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DW-1:0]          diff_t;
  typedef logic signed [PW-1:0]          prod_t;
  typedef logic signed [SW-1:0]          sum_t;

  localparam sum_t SUM_ZERO = '0;

  // Everything the final check needs for one edge.
  typedef struct packed {
    logic signed [SW-1:0] num;
    logic signed [SW-1:0] den1;
    logic signed [SW-1:0] den2;
    logic signed [PW-1:0] col_lhs;
    logic signed [PW-1:0] col_rhs;
    logic                 overlap;
  } edge_terms_t;

  // Stage handshake. A stage loads when it is empty or its contents move on.
  logic a_valid, b_valid, c_valid;
  logic adv_a, adv_b, adv_c;

  assign adv_c     = !c_valid || res.ready;
  assign adv_b     = !b_valid || adv_c;
  assign adv_a     = !a_valid || adv_b;
  assign req.ready = adv_a;
  assign res.valid = c_valid;

  // Stage A: the captured request.
  logic   a_mode;
  coord_t a_px, a_py, a_qx, a_qy, a_sx, a_sy, a_ex, a_ey;

  // Stage B: registered terms of every edge.
  logic        b_mode;
  edge_terms_t b_terms [NE];

  // Stage C: the result register.
  logic c_hit;

  // Endpoints of the first segment for each edge slot. In segment mode only
  // slot zero counts, and it carries P-Q itself.
  coord_t ea1 [NE];
  coord_t eb1 [NE];
  coord_t ea2 [NE];
  coord_t eb2 [NE];

  always_comb begin
    ea1[0] = a_px;
    eb1[0] = a_py;
    ea2[0] = a_qx;
    eb2[0] = (a_mode == srit_pkg::MODE_RECT) ? a_py : a_qy;
    ea1[1] = a_qx;
    eb1[1] = a_py;
    ea2[1] = a_qx;
    eb2[1] = a_qy;
    ea1[2] = a_qx;
    eb1[2] = a_qy;
    ea2[2] = a_px;
    eb2[2] = a_qy;
    ea1[3] = a_px;
    eb1[3] = a_qy;
    ea2[3] = a_px;
    eb2[3] = a_py;
  end

  edge_terms_t terms_next [NE];

  for (genvar g = 0; g < NE; g++) begin : g_edge
    diff_t  d_b21, d_c21, d_a21, d_d21, d_db, d_c12, d_ac, d_d12, d_a12, d_b12;
    diff_t  d_ca, d_dbb;
    prod_t  m_num0, m_num1, m_den10, m_den11, m_den20, m_den21;
    logic   vertical;
    coord_t u1, u2, v1, v2, u_lo, u_hi, v_lo, v_hi;

    assign d_b21 = DW'(eb2[g]) - DW'(eb1[g]);
    assign d_a21 = DW'(ea2[g]) - DW'(ea1[g]);
    assign d_c21 = DW'(a_ex) - DW'(a_sx);
    assign d_d21 = DW'(a_ey) - DW'(a_sy);
    assign d_db  = DW'(a_ey) - DW'(eb2[g]);
    assign d_c12 = DW'(a_sx) - DW'(a_ex);
    assign d_ac  = DW'(ea2[g]) - DW'(a_ex);
    assign d_d12 = DW'(a_sy) - DW'(a_ey);
    assign d_a12 = DW'(ea1[g]) - DW'(ea2[g]);
    assign d_b12 = DW'(eb1[g]) - DW'(eb2[g]);
    assign d_ca  = DW'(a_sx) - DW'(ea2[g]);
    assign d_dbb = DW'(a_sy) - DW'(eb2[g]);

    assign m_num0  = PW'(d_b21) * PW'(d_c21);
    assign m_num1  = PW'(d_a21) * PW'(d_d21);
    assign m_den10 = PW'(d_db) * PW'(d_c12);
    assign m_den11 = PW'(d_ac) * PW'(d_d12);
    assign m_den20 = PW'(d_db) * PW'(d_a12);
    assign m_den21 = PW'(d_ac) * PW'(d_b12);

    // Collinear overlap: project onto y when the first segment is vertical.
    assign vertical = (ea1[g] == ea2[g]);
    assign u1   = vertical ? eb1[g] : ea1[g];
    assign u2   = vertical ? eb2[g] : ea2[g];
    assign v1   = vertical ? a_sy : a_sx;
    assign v2   = vertical ? a_ey : a_ex;
    assign u_lo = (u1 > u2) ? u2 : u1;
    assign u_hi = (u1 > u2) ? u1 : u2;
    assign v_lo = (v1 > v2) ? v2 : v1;
    assign v_hi = (v1 > v2) ? v1 : v2;

    always_comb begin
      terms_next[g].num     = SW'(m_num0) - SW'(m_num1);
      terms_next[g].den1    = SW'(m_den10) + SW'(m_den11);
      terms_next[g].den2    = SW'(m_den20) + SW'(m_den21);
      terms_next[g].col_lhs = PW'(d_b12) * PW'(d_ca);
      terms_next[g].col_rhs = PW'(d_a12) * PW'(d_dbb);
      terms_next[g].overlap = (u_lo <= v_hi) && (u_hi >= v_lo);
    end
  end

  // A nonzero numerator needs both denominators between zero and it, on
  // whichever side of zero it lies. A zero numerator falls to the collinear
  // test.
  function automatic logic edge_hit(input edge_terms_t t);
    logic pos_ok;
    logic neg_ok;
    pos_ok = (t.den1 >= SUM_ZERO) && (t.den1 <= t.num) &&
             (t.den2 >= SUM_ZERO) && (t.den2 <= t.num);
    neg_ok = (t.den1 <= SUM_ZERO) && (t.den1 >= t.num) &&
             (t.den2 <= SUM_ZERO) && (t.den2 >= t.num);
    if (t.num > SUM_ZERO) begin
      return pos_ok;
    end else if (t.num < SUM_ZERO) begin
      return neg_ok;
    end else begin
      return (t.col_lhs == t.col_rhs) && t.overlap;
    end
  endfunction

  logic hit_next;

  always_comb begin
    hit_next = edge_hit(b_terms[0]);
    if (b_mode == srit_pkg::MODE_RECT) begin
      for (int i = 1; i < NE; i++) begin
        hit_next = hit_next | edge_hit(b_terms[i]);
      end
    end
  end

  // Stage occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid <= req.valid;
      end
      if (adv_b) begin
        b_valid <= a_valid;
      end
      if (adv_c) begin
        c_valid <= b_valid;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv_a && req.valid) begin
      a_mode <= req.mode;
      a_px   <= req.p_x;
      a_py   <= req.p_y;
      a_qx   <= req.q_x;
      a_qy   <= req.q_y;
      a_sx   <= req.s_x;
      a_sy   <= req.s_y;
      a_ex   <= req.e_x;
      a_ey   <= req.e_y;
    end
    if (adv_b && a_valid) begin
      b_mode  <= a_mode;
      b_terms <= terms_next;
    end
    if (adv_c && b_valid) begin
      c_hit <= hit_next;
    end
  end

  assign res.hit = c_hit;

endmodule

### hdl/srit_checker.sv
`include "assert_macros.svh"

module srit_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic res_valid,
  input logic res_ready,
  input logic res_hit
);

  // Requests accepted whose result has not yet been taken.
  logic [2:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 3'(req_valid && req_ready) - 3'(res_valid && res_ready);
    end
  end

  `ASSERT_CLKD(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_hit), "stalled result changed")
  `ASSERT_CLKD(a_ready_when_drained, clk, rst, !res_valid |-> req_ready, "request refused while output is free")
  `ASSERT_CLKD(a_no_phantom, clk, rst, res_valid |-> outstanding != 3'd0, "result without a request")
  `ASSERT_CLKD(a_depth, clk, rst, outstanding <= 3'd3, "more requests in flight than stages")
  `ASSERT_CLKD_RST(a_reset_empty, clk, rst |=> !res_valid, "result valid after reset")

endmodule

bind segment_and_rect_intersection_test_top srit_checker u_srit_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_hit   (res.hit)
);
